### rtl/core/hpg_pkg.sv
`default_nettype none
package hpg_pkg;

   // Range limits and scale factors
   localparam int HueMax  = 360;
   localparam int PctMax  = 100;
   localparam int FracMax = 10000;
   localparam int ChanMax = 255;
   localparam int Sector  = 60;

   // Reciprocal multipliers: floor(x / d) = (x * M) >> S over the value ranges used here
   // frac = floor(5 * rem / 3) for rem 0..59
   localparam int FracMul   = 855;
   localparam int FracShift = 9;
   // floor(x / 100) for x up to 10000
   localparam int PctMul    = 5243;
   localparam int PctShift  = 19;
   // floor(x / 10000) for x up to 1000000
   localparam longint FracDivMul = 64'd858994;
   localparam int     FracDivShift = 33;
   // floor(c * 255 / 100) for c up to 100
   localparam int ChanMul   = ChanMax * PctMul;

   // Sector codes
   localparam logic [2:0] SEC_RED_YEL  = 3'd0;
   localparam logic [2:0] SEC_YEL_GRN  = 3'd1;
   localparam logic [2:0] SEC_GRN_CYN  = 3'd2;
   localparam logic [2:0] SEC_CYN_BLU  = 3'd3;
   localparam logic [2:0] SEC_BLU_MAG  = 3'd4;
   localparam logic [2:0] SEC_MAG_RED  = 3'd5;

   // Input transaction
   typedef struct packed {
      logic [8:0] hue;
      logic [6:0] saturation;
      logic [6:0] brightness;
      logic       light_on;
   } hpg_req_type;

   // Numerators ahead of the divide stages
   typedef struct packed {
      logic        err;
      logic [2:0]  sector;
      logic [6:0]  inten;
      logic [13:0] p_num;
      logic [13:0] q_in;
      logic [13:0] t_in;
   } hpg_num_type;

   // Channel candidates
   typedef struct packed {
      logic       err;
      logic [2:0] sector;
      logic [6:0] inten;
      logic [6:0] p;
      logic [6:0] q;
      logic [6:0] t;
   } hpg_pqt_type;

endpackage
`default_nettype wire

### rtl/core/hpg_front.sv
`default_nettype none
module hpg_front import hpg_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        in_valid,
   output logic             in_ready,
   input  wire hpg_req_type in_data,
   output logic             out_valid,
   input  wire logic        out_ready,
   output hpg_num_type      out_data
);

   // Stage A registers: range check, sector and fraction
   logic       a_valid_ff;
   logic       a_err_ff, a_err_in;
   logic [2:0] a_sector_ff, a_sector_in;
   logic [6:0] a_inten_ff, a_inten_in;
   logic [6:0] a_sat_ff;
   logic [6:0] a_frac_ff, a_frac_in;

   // Stage B registers: numerators
   logic        b_valid_ff;
   hpg_num_type b_data_ff, b_data_in;

   logic a_adv, b_adv;
   logic [8:0]  hue_fix, base;
   logic [8:0]  rem_full;
   logic [15:0] frac_prod;
   logic [13:0] fs_prod, ts_prod;
   logic [6:0]  sat_inv, frac_inv;

   // Stall chain
   assign b_adv    = !b_valid_ff || out_ready;
   assign a_adv    = !a_valid_ff || b_adv;
   assign in_ready = a_adv;

   // Stage A logic
   always_comb begin
      a_inten_in = in_data.light_on ? in_data.brightness : 7'd0;
      a_err_in   = (in_data.hue > 9'(HueMax)) || (in_data.saturation > 7'(PctMax)) ||
                   (a_inten_in > 7'(PctMax));
      // hue 360 wraps to 0
      hue_fix = (in_data.hue == 9'(HueMax)) ? 9'd0 : in_data.hue;
      if (hue_fix >= 9'(5 * Sector)) begin
         a_sector_in = SEC_MAG_RED;
         base        = 9'(5 * Sector);
      end else if (hue_fix >= 9'(4 * Sector)) begin
         a_sector_in = SEC_BLU_MAG;
         base        = 9'(4 * Sector);
      end else if (hue_fix >= 9'(3 * Sector)) begin
         a_sector_in = SEC_CYN_BLU;
         base        = 9'(3 * Sector);
      end else if (hue_fix >= 9'(2 * Sector)) begin
         a_sector_in = SEC_GRN_CYN;
         base        = 9'(2 * Sector);
      end else if (hue_fix >= 9'(Sector)) begin
         a_sector_in = SEC_YEL_GRN;
         base        = 9'(Sector);
      end else begin
         a_sector_in = SEC_RED_YEL;
         base        = 9'd0;
      end
      rem_full  = hue_fix - base;
      frac_prod = {10'd0, rem_full[5:0]} * 16'(FracMul);
      a_frac_in = frac_prod[FracShift +: 7];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_adv) begin
         a_valid_ff <= in_valid;
      end
      if (a_adv) begin
         a_err_ff    <= a_err_in;
         a_sector_ff <= a_sector_in;
         a_inten_ff  <= a_inten_in;
         a_sat_ff    <= in_data.saturation;
         a_frac_ff   <= a_frac_in;
      end
   end

   // Stage B logic
   always_comb begin
      sat_inv  = 7'(PctMax) - a_sat_ff;
      frac_inv = 7'(PctMax) - a_frac_ff;
      fs_prod  = 14'(a_frac_ff) * 14'(a_sat_ff);
      ts_prod  = 14'(a_sat_ff) * 14'(frac_inv);
      b_data_in.err    = a_err_ff;
      b_data_in.sector = a_sector_ff;
      b_data_in.inten  = a_inten_ff;
      b_data_in.p_num  = 14'(a_inten_ff) * 14'(sat_inv);
      b_data_in.q_in   = 14'(FracMax) - fs_prod;
      b_data_in.t_in   = 14'(FracMax) - ts_prod;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_adv) begin
         b_valid_ff <= a_valid_ff;
      end
      if (b_adv) begin
         b_data_ff <= b_data_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_data  = b_data_ff;

endmodule
`default_nettype wire

### rtl/core/hpg_div.sv
`default_nettype none
module hpg_div import hpg_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        in_valid,
   output logic             in_ready,
   input  wire hpg_num_type in_data,
   output logic             out_valid,
   input  wire logic        out_ready,
   output hpg_pqt_type      out_data
);

   // Stage C registers: intensity products and P
   logic        c_valid_ff;
   logic        c_err_ff;
   logic [2:0]  c_sector_ff;
   logic [6:0]  c_inten_ff;
   logic [6:0]  c_p_ff, c_p_in;
   logic [20:0] c_qnum_ff, c_qnum_in;
   logic [20:0] c_tnum_ff, c_tnum_in;

   // Stage D registers: Q and T after the divide by 10000
   logic        d_valid_ff;
   hpg_pqt_type d_data_ff, d_data_in;

   logic c_adv, d_adv;
   logic [26:0] p_prod;
   logic [40:0] q_prod, t_prod;

   assign d_adv    = !d_valid_ff || out_ready;
   assign c_adv    = !c_valid_ff || d_adv;
   assign in_ready = c_adv;

   // Stage C logic
   always_comb begin
      p_prod    = {13'd0, in_data.p_num} * 27'(PctMul);
      c_p_in    = p_prod[PctShift +: 7];
      c_qnum_in = 21'(in_data.inten) * 21'(in_data.q_in);
      c_tnum_in = 21'(in_data.inten) * 21'(in_data.t_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (c_adv) begin
         c_valid_ff <= in_valid;
      end
      if (c_adv) begin
         c_err_ff    <= in_data.err;
         c_sector_ff <= in_data.sector;
         c_inten_ff  <= in_data.inten;
         c_p_ff      <= c_p_in;
         c_qnum_ff   <= c_qnum_in;
         c_tnum_ff   <= c_tnum_in;
      end
   end

   // Stage D logic
   always_comb begin
      q_prod = {20'd0, c_qnum_ff} * 41'(FracDivMul);
      t_prod = {20'd0, c_tnum_ff} * 41'(FracDivMul);
      d_data_in.err    = c_err_ff;
      d_data_in.sector = c_sector_ff;
      d_data_in.inten  = c_inten_ff;
      d_data_in.p      = c_p_ff;
      d_data_in.q      = q_prod[FracDivShift +: 7];
      d_data_in.t      = t_prod[FracDivShift +: 7];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else if (d_adv) begin
         d_valid_ff <= c_valid_ff;
      end
      if (d_adv) begin
         d_data_ff <= d_data_in;
      end
   end

   assign out_valid = d_valid_ff;
   assign out_data  = d_data_ff;

endmodule
`default_nettype wire

### rtl/core/hpg_pack.sv
`default_nettype none
module hpg_pack import hpg_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        in_valid,
   output logic             in_ready,
   input  wire hpg_pqt_type in_data,
   output logic             out_valid,
   input  wire logic        out_ready,
   output logic [23:0]      out_grb_word,
   output logic             out_range_error
);

   // Stage E registers: output
   logic        e_valid_ff;
   logic [23:0] e_grb_ff, e_grb_in;
   logic        e_err_ff;

   logic        e_adv;
   logic [6:0]  r_c, g_c, b_c;
   logic [27:0] r_prod, g_prod, b_prod;

   assign e_adv    = !e_valid_ff || out_ready;
   assign in_ready = e_adv;

   // Sector select, then scale to 0..255
   always_comb begin
      case (in_data.sector)
         SEC_RED_YEL: begin
            r_c = in_data.inten; g_c = in_data.t;     b_c = in_data.p;
         end
         SEC_YEL_GRN: begin
            r_c = in_data.q;     g_c = in_data.inten; b_c = in_data.p;
         end
         SEC_GRN_CYN: begin
            r_c = in_data.p;     g_c = in_data.inten; b_c = in_data.t;
         end
         SEC_CYN_BLU: begin
            r_c = in_data.p;     g_c = in_data.q;     b_c = in_data.inten;
         end
         SEC_BLU_MAG: begin
            r_c = in_data.t;     g_c = in_data.p;     b_c = in_data.inten;
         end
         default: begin
            r_c = in_data.inten; g_c = in_data.p;     b_c = in_data.q;
         end
      endcase
      r_prod = 28'(r_c) * 28'(ChanMul);
      g_prod = 28'(g_c) * 28'(ChanMul);
      b_prod = 28'(b_c) * 28'(ChanMul);
      if (in_data.err) begin
         e_grb_in = 24'd0;
      end else begin
         e_grb_in = {g_prod[PctShift +: 8], r_prod[PctShift +: 8], b_prod[PctShift +: 8]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else if (e_adv) begin
         e_valid_ff <= in_valid;
      end
      if (e_adv) begin
         e_grb_ff <= e_grb_in;
         e_err_ff <= in_data.err;
      end
   end

   assign out_valid       = e_valid_ff;
   assign out_grb_word    = e_grb_ff;
   assign out_range_error = e_err_ff;

endmodule
`default_nettype wire

### rtl/core/hsv_percent_to_grb_pixel.sv
`default_nettype none
// HSV to GRB pixel converter. Takes hue (degrees 0..360), saturation and
// brightness (percent 0..100) and an on flag, and returns the packed color
// green[23:16], red[15:8], blue[7:0]. An out-of-range operand gives
// range_error = 1 and a black color; with the light off the brightness is not
// checked. The datapath is a five-stage pipeline (range/sector, numerators,
// P and intensity products, divide by 10000, sector select and scaling), and
// one new transaction is accepted every cycle unless the pipe is held by a
// stalled output. Each stage has its own valid bit and only holds when it is
// full and the stage after it, or for the last stage the output, is stalled.
module hsv_percent_to_grb_pixel import hpg_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [8:0]  req_hue,
   input  wire logic [6:0]  req_saturation,
   input  wire logic [6:0]  req_brightness,
   input  wire logic        req_light_on,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [23:0]      rsp_grb_word,
   output logic             rsp_range_error
);

   hpg_req_type req_data;
   hpg_num_type num_data;
   hpg_pqt_type pqt_data;
   logic num_valid, num_ready, pqt_valid, pqt_ready;

   assign req_data.hue        = req_hue;
   assign req_data.saturation = req_saturation;
   assign req_data.brightness = req_brightness;
   assign req_data.light_on   = req_light_on;

   hpg_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (num_valid),
      .out_ready (num_ready),
      .out_data  (num_data)
   );

   hpg_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (num_valid),
      .in_ready  (num_ready),
      .in_data   (num_data),
      .out_valid (pqt_valid),
      .out_ready (pqt_ready),
      .out_data  (pqt_data)
   );

   hpg_pack u_pack (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (pqt_valid),
      .in_ready        (pqt_ready),
      .in_data         (pqt_data),
      .out_valid       (rsp_valid),
      .out_ready       (rsp_ready),
      .out_grb_word    (rsp_grb_word),
      .out_range_error (rsp_range_error)
   );

   // An error result always carries black
   a_err_black: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_range_error |-> rsp_grb_word == 24'd0)
      else $error("range error with nonzero color");

   // With the output stage empty nothing can hold the pipe
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("pipeline stalled with empty output");

   // Reset empties the pipe
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule
`default_nettype wire
